@@ rtl/assert_macros.svh @@
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define SEM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SEM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sem_pkg.sv @@
// types and constants of the sobel edge magnitude block
`timescale 1ns / 1ps

package sem_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 10;
  localparam int COL_OUT_W = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] MAX_HEIGHT = 11'd1024;
  localparam logic [CFG_W-1:0] MIN_SIZE   = 11'd3;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // result queue, depth is a power of two so the pointers wrap on their own
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // gradient range: each weighted column or row sum is at most 4*255
  localparam int GRAD_W = 12;

  // one result word
  typedef struct packed {
    logic                 last;
    logic [PIX_W-1:0]     value;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
  } res_t;

  // what travels with a pixel down the pipe
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 row0;     // first row, word (0,c)
    logic                 mid;      // interior pass, word (r-1,c-1)
    logic                 eol;      // end of row, word (r-1,W-1)
    logic                 rlast;    // last row, word (H-1,c)
    logic                 col_ge2;  // window holds three real columns
  } meta_t;

  // up to three result words written to the queue in one cycle
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      ent;
  } push_t;

endpackage

@@ rtl/sem_line_mem.sv @@
// two line stores packed into one synchronous memory word
`timescale 1ns / 1ps

module sem_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sem_kernel.sv @@
// 3x3 window, sobel gradients and magnitude, result word assembly
`timescale 1ns / 1ps

module sem_kernel
  import sem_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] top_px,
  input  logic [PIX_W-1:0] mid_px,
  input  logic [PIX_W-1:0] bot_px,
  input  meta_t            in_meta,
  output push_t            push
);

  // window index k*3+j, k=0 top row, j=2 newest column
  logic [PIX_W-1:0] win_r [9];
  logic             w_valid_r;
  meta_t            w_meta_r;

  logic                     g_valid_r;
  meta_t                    g_meta_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [GRAD_W-1:0] gx_nxt, gy_nxt;

  logic [GRAD_W-1:0] abs_x, abs_y, mag_sum;
  logic [PIX_W-1:0]  mag;
  res_t              cand [4];
  logic [3:0]        vld;
  logic [3:0]        lst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (in_valid) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= top_px;
      win_r[5] <= mid_px;
      win_r[8] <= bot_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
    end else begin
      w_valid_r <= in_valid;
      g_valid_r <= w_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    w_meta_r <= in_meta;
    g_meta_r <= w_meta_r;
    gx_r     <= gx_nxt;
    gy_r     <= gy_nxt;
  end

  always_comb begin
    gx_nxt = $signed(GRAD_W'(win_r[2]) + (GRAD_W'(win_r[5]) << 1) + GRAD_W'(win_r[8]))
           - $signed(GRAD_W'(win_r[0]) + (GRAD_W'(win_r[3]) << 1) + GRAD_W'(win_r[6]));
    gy_nxt = $signed(GRAD_W'(win_r[0]) + (GRAD_W'(win_r[1]) << 1) + GRAD_W'(win_r[2]))
           - $signed(GRAD_W'(win_r[6]) + (GRAD_W'(win_r[7]) << 1) + GRAD_W'(win_r[8]));
  end

  always_comb begin
    abs_x   = gx_r[GRAD_W-1] ? GRAD_W'(-gx_r) : GRAD_W'(gx_r);
    abs_y   = gy_r[GRAD_W-1] ? GRAD_W'(-gy_r) : GRAD_W'(gy_r);
    mag_sum = abs_x + abs_y;
    mag     = (mag_sum > GRAD_W'(255)) ? 8'd255 : mag_sum[PIX_W-1:0];
  end

  // candidates in output order: first row, interior, end of row, last row
  always_comb begin
    logic [1:0] idx;
    idx = 2'd0;

    vld[0] = g_valid_r & g_meta_r.row0;
    vld[1] = g_valid_r & g_meta_r.mid;
    vld[2] = g_valid_r & g_meta_r.eol;
    vld[3] = g_valid_r & g_meta_r.rlast;

    lst[3] = vld[3];
    lst[2] = vld[2] & ~vld[3];
    lst[1] = vld[1] & ~vld[2] & ~vld[3];
    lst[0] = vld[0] & ~vld[1] & ~vld[2] & ~vld[3];

    cand[0] = '{last: lst[0], value: '0, col: g_meta_r.col, row: '0};
    cand[1] = '{last: lst[1], value: (g_meta_r.col_ge2 ? mag : '0),
                col: g_meta_r.col - 1'b1, row: g_meta_r.row - 1'b1};
    cand[2] = '{last: lst[2], value: '0, col: g_meta_r.col, row: g_meta_r.row - 1'b1};
    cand[3] = '{last: lst[3], value: '0, col: g_meta_r.col, row: g_meta_r.row};

    push.ent = '0;
    for (int k = 0; k < 4; k++) begin
      if (vld[k] && idx != 2'd3) begin
        push.ent[idx] = cand[k];
        idx = idx + 2'd1;
      end
    end
    push.cnt = idx;
  end

endmodule

@@ rtl/sem_out_fifo.sv @@
// result queue, up to three words in per cycle, one word out
`timescale 1ns / 1ps

module sem_out_fifo
  import sem_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  head_valid,
  output res_t  head
);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_nxt;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (FIFO_CW'(k) < FIFO_CW'(push.cnt)) begin
        mem_r[wr_ptr_r + FIFO_AW'(k)] <= push.ent[k];
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + FIFO_CW'(push.cnt) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

endmodule

@@ rtl/sobel_edge_magnitude.sv @@
// top level of the sobel 3x3 edge magnitude block
//
//  port group  dir  word contents
//  in_*        in   pixel_in [7:0]
//  out_*       out  out_row [9:0], out_col [19:10], edge_value [27:20]; tlast = run_last
//  cfg_*       in   index 0 frame_width, index 1 frame_height, 11-bit data
//
// one pixel per cycle while the result queue has room; the output port then sets
// the pace: a last-row pixel past column 0 gives two words and each row end one extra word
// first word of a pixel passes the ram read stage, the window, the gradient registers and the queue to out_*
// line store: one 16-bit synchronous ram, read at accept, written back in the next cycle
// reset (synchronous) clears counters, window, pipe and queue; the ram is not cleared
// out_tready low fills the 8-word queue; in_tready drops once the queue plus words
// still in the pipe could not take all words of the next pixel
`timescale 1ns / 1ps

module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input pixels
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] pixel_in
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [9:0] out_row, [19:10] out_col, [27:20] edge_value
  output logic                 out_tlast,  // run_last
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (SW > CFG_W) ? SW : CFG_W;

  // configuration
  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic [CMP_W-1:0] fw_ext, w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             cfg_hit;

  // raster position
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             c_last, r_last;

  // accept and credits
  logic               in_hs, out_hs;
  meta_t              meta_in;
  logic [1:0]         n_words;
  logic [FIFO_CW-1:0] used_r, used_nxt;

  // stage after the ram read
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  meta_t            s1_meta_r;
  logic [15:0]      rd_data;   // {lower, upper}

  push_t push;
  logic  head_valid;
  res_t  head;

  assign cfg_hit = cfg_wr_en && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= SIZE_RESET;
      frame_height_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the supported range
  always_comb begin
    fw_ext = CMP_W'(frame_width_r);
    if (fw_ext < CMP_W'(MIN_SIZE)) begin
      w_eff = CMP_W'(MIN_SIZE);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (frame_height_r < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else if (frame_height_r > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign c_last = (CMP_W'(col_r) == w_eff - 1'b1);
  assign r_last = (CFG_W'(row_r) == h_eff - 1'b1);

  // which result words this pixel will produce
  always_comb begin
    meta_in.row     = row_r;
    meta_in.col     = COL_OUT_W'(col_r);
    meta_in.row0    = (row_r == '0);
    meta_in.mid     = (row_r >= ROW_W'(2)) && (col_r != '0);
    meta_in.eol     = (row_r >= ROW_W'(2)) && c_last;
    meta_in.rlast   = r_last;
    meta_in.col_ge2 = (col_r >= CW'(2));
    n_words = 2'(meta_in.row0) + 2'(meta_in.mid) + 2'(meta_in.eol) + 2'(meta_in.rlast);
  end

  // a pixel is taken only when the queue is sure to hold all its words
  assign in_tready = (used_r + FIFO_CW'(n_words)) <= FIFO_CW'(FIFO_DEPTH);
  assign in_hs     = in_tvalid && in_tready;
  assign out_hs    = head_valid && out_tready;

  always_comb begin
    used_nxt = used_r + (in_hs ? FIFO_CW'(n_words) : '0) - FIFO_CW'(out_hs);
    if (c_last) begin
      col_nxt = '0;
      row_nxt = r_last ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      used_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      s1_valid_r <= in_hs;
      if (cfg_hit) begin
        // a write to frame_width or frame_height restarts the frame
        row_r <= '0;
        col_r <= '0;
      end else if (in_hs) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      s1_pix_r  <= in_tdata;
      s1_col_r  <= col_r;
      s1_meta_r <= meta_in;
    end
  end

  // read at accept, write back in the next cycle; the next read of the same
  // column is a whole row (three or more pixels) away, so no overlap
  sem_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (16)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_hs),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data ({s1_pix_r, rd_data[15:8]})   // row r-1 moves to the low byte, new pixel goes to the high byte
  );

  sem_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid_r),
    .top_px   (rd_data[7:0]),
    .mid_px   (rd_data[15:8]),
    .bot_px   (s1_pix_r),
    .in_meta  (s1_meta_r),
    .push     (push)
  );

  sem_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_hs),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = {4'b0000, head.value, head.col, head.row};
  assign out_tlast  = head.last;

endmodule

@@ rtl/sem_checker.sv @@
// port-level checks of the sobel edge magnitude block
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // reset empties the queue and leaves room for the first pixel
  `SEM_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> (!out_tvalid && in_tready), "queue not empty after reset")

  // a stalled word holds
  `SEM_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "result word changed under stall")

  // first row is border
  `SEM_ASSERT(a_row0_zero, clk, rst_n, (out_tvalid && out_tdata[9:0] == 10'd0) |-> (out_tdata[27:20] == 8'd0), "nonzero value on first row")

  // first column is border
  `SEM_ASSERT(a_col0_zero, clk, rst_n, (out_tvalid && out_tdata[19:10] == 10'd0) |-> (out_tdata[27:20] == 8'd0), "nonzero value on first column")

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
